### rtl/core/ffha_pkg.sv
// Shared constants, types and state codes for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

	localparam int HEAP_BYTES = 4096;
	localparam int ADDR_W     = $clog2(HEAP_BYTES);
	localparam int POS_W      = ADDR_W + 1;
	localparam int HDR_W      = ADDR_W + 2;
	localparam int SIZE_W     = 13;
	localparam int RES_W      = 12;
	localparam int CMP_W      = ((POS_W > SIZE_W) ? POS_W : SIZE_W) + 1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOSPACE  = 2'd1,
		ST_BADPTR   = 2'd2,
		ST_NOTALLOC = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WREQ,
		S_WCHK,
		S_SPLIT,
		S_NREQ,
		S_NCHK
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [HDR_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage
`default_nettype wire

### rtl/core/first_fit_heap_allocator.sv
// Top level: first-fit allocator sequencer walking the block header list.
//
// Channel   Direction  Handshake            Fields
// request   in         start & !busy        mode, alloc_size, free_offset
// result    out        done (one cycle)     status, result_offset
//
// Each visited block takes a header read from the registered-read header
// memory (S_WREQ), then the check (S_WCHK). A split adds S_SPLIT; a free
// adds S_NREQ and S_NCHK for the neighbor read. done rises the cycle after
// the finishing step. A rejected size or pointer finishes at once. After
// reset header 0 reads as one free block through a flag, so no clearing pass
// runs. The receiver cannot stall; the result is shown for one cycle only.
`default_nettype none
module first_fit_heap_allocator
	import ffha_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              mode,
	input  wire logic [SIZE_W-1:0] alloc_size,
	input  wire logic [SIZE_W-1:0] free_offset,
	output logic                   done,
	output logic [1:0]             status,
	output logic [RES_W-1:0]       result_offset
);

	localparam logic [POS_W:0] HEAP_END = (POS_W+1)'(HEAP_BYTES);

	state_t state_q, state_d;

	logic              mode_q;
	logic [POS_W-1:0]  need_q;
	logic [POS_W:0]    off_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  prev_q;
	logic [HDR_W-1:0]  prevh_q;
	logic [HDR_W-1:0]  h_q;
	logic [POS_W-1:0]  rem_q;
	logic [POS_W-1:0]  nxt_q;
	logic              last_q;
	logic              done_q;
	status_t           status_q;
	logic [RES_W-1:0]  result_q;

	mem_req_t                 mreq;
	logic signed [HDR_W-1:0]  rdata;

	logic              size_bad, off_bad;
	logic              hneg;
	logic [HDR_W-1:0]  habs;
	logic [POS_W-1:0]  len;
	logic [POS_W:0]    end_sum;
	logic              len_bad, at_end;
	logic [POS_W-1:0]  diff;
	logic              fit, match;
	logic              prev_free, next_free;

	logic              fin;
	status_t           fin_status;
	logic              fin_res;

	ffha_hdr_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (rdata)
	);

	assign size_bad = (alloc_size == '0) ||
		(CMP_W'(alloc_size) > CMP_W'(HEAP_BYTES - 2));
	assign off_bad  = CMP_W'(free_offset) > CMP_W'(HEAP_BYTES - 3);

	assign hneg      = rdata[HDR_W-1];
	assign habs      = hneg ? (~rdata + 1'b1) : rdata;
	assign len       = habs[POS_W-1:0];
	assign end_sum   = {1'b0, pos_q} + {1'b0, len};
	assign len_bad   = (len == '0) || (end_sum > HEAP_END);
	assign at_end    = end_sum == HEAP_END;
	assign diff      = len - need_q;
	assign fit       = hneg && (len >= need_q) &&
		((diff == '0) || (diff > POS_W'(2)));
	assign match     = ({1'b0, pos_q} + (POS_W+1)'(2)) == off_q;
	assign prev_free = (prev_q != pos_q) && prevh_q[HDR_W-1];
	assign next_free = !last_q && hneg;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if ((!mode && size_bad) || (mode && off_bad)) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_WREQ;
					end
				end
			end
			S_WREQ: state_d = S_WCHK;
			S_WCHK: begin
				if (len_bad) begin
					state_d = S_IDLE;
				end else if (!mode_q) begin
					priority if (fit) begin
						state_d = (diff != '0) ? S_SPLIT : S_IDLE;
					end else if (at_end) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_WREQ;
					end
				end else begin
					priority if (match) begin
						state_d = hneg ? S_IDLE : S_NREQ;
					end else if (at_end) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_WREQ;
					end
				end
			end
			S_SPLIT: state_d = S_IDLE;
			S_NREQ:  state_d = S_NCHK;
			S_NCHK:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mreq.we    = 1'b0;
		mreq.waddr = pos_q[ADDR_W-1:0];
		mreq.wdata = '0;
		mreq.raddr = pos_q[ADDR_W-1:0];
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_res    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start && !mode && size_bad) begin
					fin        = 1'b1;
					fin_status = ST_NOSPACE;
				end else if (start && mode && off_bad) begin
					fin        = 1'b1;
					fin_status = ST_BADPTR;
				end
			end
			S_WREQ: ;
			S_WCHK: begin
				if (len_bad) begin
					fin        = 1'b1;
					fin_status = mode_q ? ST_NOTALLOC : ST_NOSPACE;
				end else if (!mode_q) begin
					if (fit) begin
						mreq.we    = 1'b1;
						mreq.wdata = HDR_W'(need_q);
						fin        = (diff == '0);
						fin_res    = 1'b1;
					end else if (at_end) begin
						fin        = 1'b1;
						fin_status = ST_NOSPACE;
					end
				end else begin
					if (match && hneg) begin
						fin        = 1'b1;
						fin_status = ST_NOTALLOC;
					end else if (!match && at_end) begin
						fin        = 1'b1;
						fin_status = ST_NOTALLOC;
					end
				end
			end
			S_SPLIT: begin
				mreq.we    = 1'b1;
				mreq.waddr = ADDR_W'(pos_q + need_q);
				mreq.wdata = -HDR_W'(rem_q);
				fin        = 1'b1;
				fin_res    = 1'b1;
			end
			S_NREQ: begin
				mreq.raddr = nxt_q[ADDR_W-1:0];
			end
			S_NCHK: begin
				mreq.we = 1'b1;
				fin     = 1'b1;
				priority if (prev_free && next_free) begin
					mreq.waddr = prev_q[ADDR_W-1:0];
					mreq.wdata = prevh_q - h_q + rdata;
				end else if (prev_free) begin
					mreq.waddr = prev_q[ADDR_W-1:0];
					mreq.wdata = prevh_q - h_q;
				end else if (next_free) begin
					mreq.wdata = rdata - h_q;
				end else begin
					mreq.wdata = -h_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q <= mode;
			need_q <= POS_W'(CMP_W'(alloc_size) + CMP_W'(2));
			off_q  <= (POS_W+1)'(free_offset);
			pos_q  <= '0;
			prev_q <= '0;
		end
		if (state_q == S_WCHK) begin
			h_q    <= rdata;
			rem_q  <= diff;
			nxt_q  <= end_sum[POS_W-1:0];
			last_q <= at_end;
			if (!(mode_q ? match : fit)) begin
				prev_q  <= pos_q;
				prevh_q <= rdata;
				pos_q   <= end_sum[POS_W-1:0];
			end
		end
		if (fin) begin
			status_q <= fin_status;
			result_q <= fin_res ? RES_W'(pos_q + POS_W'(2)) : '0;
		end
	end

	assign busy          = state_q != S_IDLE;
	assign done          = done_q;
	assign status        = status_q;
	assign result_offset = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a walk is still running");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (result_offset == '0))
		else $error("failed request carries a nonzero offset");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WREQ) |-> ({1'b0, pos_q} < HEAP_END))
		else $error("walk position left the heap");

	a_split_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT) |=> (done && status == ST_OK))
		else $error("split did not end in a successful allocation");

endmodule
`default_nettype wire

### rtl/core/ffha_hdr_mem.sv
// Block header memory with registered read; entry 0 reads as one free block until written.
`default_nettype none
module ffha_hdr_mem
	import ffha_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire mem_req_t                req,
	output logic signed [HDR_W-1:0]      rdata
);

	localparam logic [HDR_W-1:0] HDR_INIT = HDR_W'(-HEAP_BYTES);

	logic [HDR_W-1:0] mem [HEAP_BYTES];
	logic [HDR_W-1:0] rdata_q;
	logic             h0_wr_q;
	logic             rd_init_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h0_wr_q   <= 1'b0;
			rd_init_q <= 1'b0;
		end else begin
			if (req.we && (req.waddr == '0)) begin
				h0_wr_q <= 1'b1;
			end
			rd_init_q <= (req.raddr == '0) && !h0_wr_q;
		end
	end

	assign rdata = rd_init_q ? HDR_INIT : rdata_q;

endmodule
`default_nettype wire
